// File: src/cpa_pkg.sv
// Shared types, codes and constants of the command priority array.
// Depends on nothing; cpa_core and command_priority_array import it.
package cpa_pkg;

  localparam int unsigned LevelsDef        = 16;
  localparam int unsigned ReservedPriority = 6;
  localparam int unsigned ValueW           = 32;

  typedef enum logic [1:0] {
    OP_WRITE      = 2'd0,
    OP_RELINQUISH = 2'd1,
    OP_READ_ONE   = 2'd2,
    OP_READ_ALL   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_PRIO    = 2'd1,
    ST_DENIED      = 2'd2,
    ST_BAD_INDEX   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_REAL  = 2'd1,
    KIND_NULL  = 2'd2,
    KIND_COUNT = 2'd3
  } kind_e;

  typedef enum logic [0:0] {
    REG_FALLBACK_VALUE  = 1'b0,
    REG_SUPPRESS_CHANGE = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [7:0]        slot;
    logic [ValueW-1:0] level_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        entry_kind;
    logic [ValueW-1:0] entry_data;
    logic [ValueW-1:0] present_value;
    logic [4:0]        active_level;
    logic              changed;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [0:0]        index;
    logic [ValueW-1:0] data;
  } cfg_t;

  typedef struct packed {
    logic [ValueW-1:0] fallback_value;
    logic              suppress_change;
  } cfg_regs_t;

endpackage

// File: src/cpa_stream_if.sv
// Valid/ready channel carrying one payload item per handshake.
// The payload type is set per instance from the types in cpa_pkg.
interface cpa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: src/cpa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module cpa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/cpa_core.sv
// Sequencer of the priority array: decodes items, keeps the occupancy mask and
// winner, drives the level store and the result register. Uses cpa_pkg, cpa_ram.
module cpa_core #(
  parameter int unsigned LEVELS = cpa_pkg::LevelsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cpa_pkg::cfg_regs_t  cfg_i,
  cpa_stream_if.sink          cmd_i,
  cpa_stream_if.source        rsp_o
);
  import cpa_pkg::*;

  localparam int unsigned IdxW = $clog2(LEVELS);
  localparam int unsigned WinW = $clog2(LEVELS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic              state_q, state_d;
  logic [LEVELS-1:0] mask_q, mask_d;
  logic [WinW-1:0]   win_q, win_d;
  logic [ValueW-1:0] present_q, present_d;
  logic [1:0]        op_q, op_d;
  logic [1:0]        status_q, status_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              chg_q, chg_d;
  logic              fall_q, fall_d;
  logic              found_q, found_d;
  logic [IdxW-1:0]   nxt_q, nxt_d;
  logic              count_q, count_d;
  rsp_t              rsp_q, rsp_d;
  logic              rsp_valid_q, rsp_valid_d;

  logic              ram_we, ram_re;
  logic [IdxW-1:0]   ram_raddr;
  logic [ValueW-1:0] ram_rdata;

  cmd_t              cmd;
  logic              accept;
  logic              slot_out;
  logic [IdxW-1:0]   slot_idx;
  logic [LEVELS-1:0] mask_clr;
  logic [LEVELS-1:0] above;
  logic [LEVELS-1:0] lowest;
  logic [IdxW-1:0]   lowest_idx;
  logic              out_free;
  logic              is_last;
  logic [ValueW-1:0] fall_value;
  logic [WinW-1:0]   fall_win;

  cpa_ram #(
    .Width(ValueW),
    .Depth(LEVELS)
  ) u_level_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_idx),
    .wdata_i(cmd.level_value),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign cmd      = cmd_i.payload;
  assign cmd_i.ready = (state_q == ST_IDLE);
  assign accept   = cmd_i.valid && (state_q == ST_IDLE);
  assign slot_out = (cmd.slot == 8'd0) || (cmd.slot > 8'(LEVELS));
  assign slot_idx = IdxW'(cmd.slot - 8'd1);
  assign mask_clr = mask_q & ~(LEVELS'(1) << slot_idx);

  // Next occupied level below the relinquished one: isolate the lowest set bit
  // above it, then encode that one-hot vector.
  assign above  = mask_clr & ({LEVELS{1'b1}} << ({1'b0, slot_idx} + (IdxW + 1)'(1)));
  assign lowest = above & (~above + LEVELS'(1));

  always_comb begin
    lowest_idx = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (lowest[i]) begin
        lowest_idx = lowest_idx | IdxW'(i);
      end
    end
  end

  assign out_free   = !rsp_valid_q || rsp_o.ready;
  assign is_last    = (op_q != OP_READ_ALL) || (idx_q == IdxW'(LEVELS - 1));
  assign fall_value = found_q ? ram_rdata : cfg_i.fallback_value;
  assign fall_win   = found_q ? WinW'(nxt_q) : WinW'(LEVELS);

  always_comb begin
    state_d     = state_q;
    mask_d      = mask_q;
    win_d       = win_q;
    present_d   = present_q;
    op_d        = op_q;
    status_d    = status_q;
    idx_d       = idx_q;
    chg_d       = chg_q;
    fall_d      = fall_q;
    found_d     = found_q;
    nxt_d       = nxt_q;
    count_d     = count_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = slot_idx;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EMIT;
          op_d    = cmd.operation;
          idx_d   = slot_idx;
          chg_d   = 1'b0;
          fall_d  = 1'b0;
          count_d = 1'b0;
          status_d = ST_OK;
          case (cmd.operation) inside
            OP_WRITE, OP_RELINQUISH: begin
              if (cmd.slot == 8'(ReservedPriority)) begin
                status_d = ST_DENIED;
              end else if (slot_out) begin
                status_d = ST_BAD_PRIO;
              end else if (cmd.operation == OP_WRITE) begin
                ram_we = 1'b1;
                mask_d = mask_q | (LEVELS'(1) << slot_idx);
                if (WinW'(slot_idx) <= win_q) begin
                  win_d     = WinW'(slot_idx);
                  present_d = cmd.level_value;
                  chg_d     = (cmd.level_value != present_q) && !cfg_i.suppress_change;
                end
              end else begin
                mask_d  = mask_clr;
                fall_d  = (WinW'(slot_idx) == win_q);
                found_d = |above;
                nxt_d   = lowest_idx;
                ram_re  = 1'b1;
                ram_raddr = lowest_idx;
              end
            end
            OP_READ_ONE: begin
              if (cmd.slot == 8'd0) begin
                count_d = 1'b1;
              end else if (cmd.slot > 8'(LEVELS)) begin
                status_d = ST_BAD_INDEX;
              end else begin
                ram_re = 1'b1;
              end
            end
            default: begin
              idx_d     = '0;
              ram_re    = 1'b1;
              ram_raddr = '0;
            end
          endcase
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          rsp_valid_d         = 1'b1;
          rsp_d.status        = status_q;
          rsp_d.entry_kind    = KIND_NONE;
          rsp_d.entry_data    = '0;
          rsp_d.changed       = 1'b0;
          rsp_d.last          = is_last;
          rsp_d.present_value = present_q;
          rsp_d.active_level  = 5'(win_q);
          case (op_q) inside
            OP_WRITE, OP_RELINQUISH: begin
              rsp_d.changed = chg_q;
              if (fall_q) begin
                present_d           = fall_value;
                win_d               = fall_win;
                rsp_d.present_value = fall_value;
                rsp_d.active_level  = 5'(fall_win);
                rsp_d.changed = (fall_value != present_q) && !cfg_i.suppress_change;
              end
            end
            default: begin
              if (status_q == ST_BAD_INDEX) begin
                rsp_d.entry_kind = KIND_NONE;
              end else if (count_q) begin
                rsp_d.entry_kind = KIND_COUNT;
                rsp_d.entry_data = ValueW'(LEVELS);
              end else if (mask_q[idx_q]) begin
                rsp_d.entry_kind = KIND_REAL;
                rsp_d.entry_data = ram_rdata;
              end else begin
                rsp_d.entry_kind = KIND_NULL;
              end
            end
          endcase
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d     = idx_q + IdxW'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_q + IdxW'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mask_q      <= '0;
      win_q       <= WinW'(LEVELS);
      present_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mask_q      <= mask_d;
      win_q       <= win_d;
      present_q   <= present_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    status_q <= status_d;
    idx_q    <= idx_d;
    chg_q    <= chg_d;
    fall_q   <= fall_d;
    found_q  <= found_d;
    nxt_q    <= nxt_d;
    count_q  <= count_d;
    rsp_q    <= rsp_d;
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

endmodule

// File: src/command_priority_array.sv
// Command priority array for an analog output. Every command item is accepted
// in ST_IDLE, which decodes it, updates the occupancy mask and the winner and,
// for a read or a relinquish, starts a read of the level store; ST_EMIT then
// loads the result register once it is free. A read-all item stays in ST_EMIT
// for LEVELS results, as the single read port of the level store yields one
// entry per cycle while the output is free. A new command is taken only once
// the previous one has handed over its last result, while that result may
// still wait at the output. Configuration writes are accepted in any cycle.
// Uses cpa_pkg, cpa_stream_if and cpa_core.
module command_priority_array #(
  parameter int unsigned LEVELS = cpa_pkg::LevelsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cpa_stream_if.sink    cmd_i,
  cpa_stream_if.source  rsp_o,
  cpa_stream_if.sink    cfg_i
);
  import cpa_pkg::*;

  // Configuration registers. The relinquish default is only sampled when a
  // relinquish falls back to it, so writing it never moves the present value.
  cfg_regs_t cfg_q, cfg_d;
  cfg_t      cfg_wr;

  assign cfg_wr      = cfg_i.payload;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_wr.index)
        REG_FALLBACK_VALUE:  cfg_d.fallback_value  = cfg_wr.data;
        REG_SUPPRESS_CHANGE: cfg_d.suppress_change = cfg_wr.data[0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The core holds the occupancy mask, the winning level and the present value
  // in flip-flops and the level values in a one-port-each RAM.
  cpa_core #(
    .LEVELS(LEVELS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_q),
    .cmd_i (cmd_i),
    .rsp_o (rsp_o)
  );

endmodule
